[hw/rtl/rm2q_pkg.sv]
// shared widths, types and constants of the rotation matrix to quaternion block
`default_nettype none

package rm2q_pkg;

	localparam int DATA_W   = 16;
	localparam int FRAC_W   = 14;
	localparam int RAD_W    = 17;
	localparam int NUM_W    = 17;
	localparam int TRACE_W  = 19;
	localparam int SQ_IN_W  = 33;
	localparam int SQ_OUT_W = 17;
	localparam int SQRT_LAT = 17;
	localparam int DIVD_W   = NUM_W + FRAC_W;
	localparam int DIV_LAT  = DIVD_W;
	localparam int QUART_W  = SQ_OUT_W - 2;
	localparam int SQR_W    = 31;
	localparam int Q_DEPTH  = 4;
	localparam int Q_PTR_W  = 2;
	localparam int Q_CNT_W  = 3;

	localparam logic [SQ_IN_W-1:0] UNIT_NORM = SQ_IN_W'(1) << (2 * FRAC_W);
	localparam logic signed [TRACE_W-1:0] ONE_FIX = TRACE_W'(1) << FRAC_W;

	// component that the square root feeds directly
	typedef enum logic [1:0] {
		SEL_X = 2'd0,
		SEL_Y = 2'd1,
		SEL_Z = 2'd2,
		SEL_W = 2'd3
	} sel_t;

	typedef struct packed {
		sel_t                    sel;
		logic [RAD_W-1:0]        rad;
		logic signed [NUM_W-1:0] num0;
		logic signed [NUM_W-1:0] num1;
		logic signed [NUM_W-1:0] num2;
	} job_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] x;
		logic signed [DATA_W-1:0] y;
		logic signed [DATA_W-1:0] z;
		logic signed [DATA_W-1:0] w;
	} quat_t;

endpackage

`default_nettype wire

[hw/rtl/rm2q_mat_if.sv]
// matrix input channel
`default_nettype none

interface rm2q_mat_if;
	logic valid;
	logic ready;
	logic signed [rm2q_pkg::DATA_W-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;

	modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
		input ready);
	modport sink (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
		output ready);
endinterface

`default_nettype wire

[hw/rtl/rm2q_quat_if.sv]
// quaternion output channel
`default_nettype none

interface rm2q_quat_if;
	logic valid;
	logic ready;
	logic signed [rm2q_pkg::DATA_W-1:0] quat_x, quat_y, quat_z, quat_w;

	modport source (output valid, quat_x, quat_y, quat_z, quat_w, input ready);
	modport sink (input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

`default_nettype wire

[hw/rtl/rm2q_front.sv]
// front end: branch choice, radicand and numerators, one register
`default_nettype none

module rm2q_front (
	input  wire logic   clk,
	input  wire logic   arst_n,
	rm2q_mat_if.sink    mat,
	output rm2q_pkg::job_t job,
	output logic        job_vld,
	input  wire logic   q_full
);

	logic signed [rm2q_pkg::TRACE_W-1:0] a00, a11, a22, t, rad;
	rm2q_pkg::job_t job_d, job_s1;
	logic vld_s1;
	logic accept;

	assign a00 = rm2q_pkg::TRACE_W'(mat.m00);
	assign a11 = rm2q_pkg::TRACE_W'(mat.m11);
	assign a22 = rm2q_pkg::TRACE_W'(mat.m22);
	assign t   = a00 + a11 + a22 + rm2q_pkg::ONE_FIX;

	always_comb begin
		job_d = '0;
		rad   = '0;
		priority if (t > 0) begin
			job_d.sel  = rm2q_pkg::SEL_W;
			rad        = t;
			job_d.num0 = rm2q_pkg::NUM_W'(mat.m12) - rm2q_pkg::NUM_W'(mat.m21);
			job_d.num1 = rm2q_pkg::NUM_W'(mat.m20) - rm2q_pkg::NUM_W'(mat.m02);
			job_d.num2 = rm2q_pkg::NUM_W'(mat.m01) - rm2q_pkg::NUM_W'(mat.m10);
		end else if (mat.m00 > mat.m11 && mat.m00 > mat.m22) begin
			job_d.sel  = rm2q_pkg::SEL_X;
			rad        = rm2q_pkg::ONE_FIX + a00 - a11 - a22;
			job_d.num0 = rm2q_pkg::NUM_W'(mat.m10) + rm2q_pkg::NUM_W'(mat.m01);
			job_d.num1 = rm2q_pkg::NUM_W'(mat.m02) + rm2q_pkg::NUM_W'(mat.m20);
			job_d.num2 = rm2q_pkg::NUM_W'(mat.m12) - rm2q_pkg::NUM_W'(mat.m21);
		end else if (mat.m11 > mat.m22) begin
			job_d.sel  = rm2q_pkg::SEL_Y;
			rad        = rm2q_pkg::ONE_FIX + a11 - a00 - a22;
			job_d.num0 = rm2q_pkg::NUM_W'(mat.m10) + rm2q_pkg::NUM_W'(mat.m01);
			job_d.num1 = rm2q_pkg::NUM_W'(mat.m21) + rm2q_pkg::NUM_W'(mat.m12);
			job_d.num2 = rm2q_pkg::NUM_W'(mat.m20) - rm2q_pkg::NUM_W'(mat.m02);
		end else begin
			job_d.sel  = rm2q_pkg::SEL_Z;
			rad        = rm2q_pkg::ONE_FIX + a22 - a00 - a11;
			job_d.num0 = rm2q_pkg::NUM_W'(mat.m20) + rm2q_pkg::NUM_W'(mat.m02);
			job_d.num1 = rm2q_pkg::NUM_W'(mat.m21) + rm2q_pkg::NUM_W'(mat.m12);
			job_d.num2 = rm2q_pkg::NUM_W'(mat.m01) - rm2q_pkg::NUM_W'(mat.m10);
		end
		// not a rotation: negative radicand clamps to zero
		job_d.rad = (rad > 0) ? rad[rm2q_pkg::RAD_W-1:0] : '0;
	end

	assign mat.ready = !vld_s1 || !q_full;
	assign accept    = mat.valid && mat.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (!q_full) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			job_s1 <= job_d;
		end
	end

	assign job     = job_s1;
	assign job_vld = vld_s1;

endmodule

`default_nettype wire

[hw/rtl/rm2q_queue.sv]
// short job queue between front and back
`default_nettype none

module rm2q_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire rm2q_pkg::job_t  wr_job,
	input  wire logic            push,
	input  wire logic            pop,
	output rm2q_pkg::job_t       rd_job,
	output logic                 full,
	output logic                 empty
);

	rm2q_pkg::job_t mem_q [rm2q_pkg::Q_DEPTH];
	logic [rm2q_pkg::Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [rm2q_pkg::Q_CNT_W-1:0] cnt_q;
	logic do_push, do_pop;

	assign full    = (cnt_q == rm2q_pkg::Q_CNT_W'(rm2q_pkg::Q_DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_job  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/rm2q_sqrt.sv]
// pipelined integer square root, one result bit per stage
`default_nettype none

module rm2q_sqrt (
	input  wire logic                          clk,
	input  wire logic                          en,
	input  wire logic [rm2q_pkg::SQ_IN_W-1:0]  rad,
	output logic [rm2q_pkg::SQ_OUT_W-1:0]      root
);

	localparam int BITS_W = 2 * rm2q_pkg::SQRT_LAT;
	localparam int REM_W  = rm2q_pkg::SQ_OUT_W + 1;
	localparam int CUR_W  = REM_W + 2;

	logic [REM_W-1:0]              rem_q  [rm2q_pkg::SQRT_LAT];
	logic [rm2q_pkg::SQ_OUT_W-1:0] root_q [rm2q_pkg::SQRT_LAT];
	logic [BITS_W-1:0]             bits_q [rm2q_pkg::SQRT_LAT];

	logic [REM_W-1:0]              rem_i  [rm2q_pkg::SQRT_LAT];
	logic [rm2q_pkg::SQ_OUT_W-1:0] root_i [rm2q_pkg::SQRT_LAT];
	logic [BITS_W-1:0]             bits_i [rm2q_pkg::SQRT_LAT];
	logic [REM_W-1:0]              rem_n  [rm2q_pkg::SQRT_LAT];
	logic [rm2q_pkg::SQ_OUT_W-1:0] root_n [rm2q_pkg::SQRT_LAT];
	logic [CUR_W-1:0]              cur    [rm2q_pkg::SQRT_LAT];
	logic [CUR_W-1:0]              trial  [rm2q_pkg::SQRT_LAT];

	always_comb begin
		for (int s = 0; s < rm2q_pkg::SQRT_LAT; s++) begin
			if (s == 0) begin
				rem_i[s]  = '0;
				root_i[s] = '0;
				bits_i[s] = BITS_W'(rad);
			end else begin
				rem_i[s]  = rem_q[s-1];
				root_i[s] = root_q[s-1];
				bits_i[s] = bits_q[s-1];
			end
			cur[s]   = {rem_i[s], bits_i[s][BITS_W-1 -: 2]};
			trial[s] = CUR_W'({root_i[s], 2'b01});
			if (cur[s] >= trial[s]) begin
				rem_n[s]  = REM_W'(cur[s] - trial[s]);
				root_n[s] = {root_i[s][rm2q_pkg::SQ_OUT_W-2:0], 1'b1};
			end else begin
				rem_n[s]  = cur[s][REM_W-1:0];
				root_n[s] = {root_i[s][rm2q_pkg::SQ_OUT_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int s = 0; s < rm2q_pkg::SQRT_LAT; s++) begin
				rem_q[s]  <= rem_n[s];
				root_q[s] <= root_n[s];
				bits_q[s] <= bits_i[s] << 2;
			end
		end
	end

	assign root = root_q[rm2q_pkg::SQRT_LAT-1];

endmodule

`default_nettype wire

[hw/rtl/rm2q_div.sv]
// pipelined signed fixed point divide with saturation, one quotient bit per stage
`default_nettype none

module rm2q_div (
	input  wire logic                                 clk,
	input  wire logic                                 en,
	input  wire logic signed [rm2q_pkg::NUM_W-1:0]    num,
	input  wire logic [rm2q_pkg::SQ_OUT_W-1:0]        den,
	output logic signed [rm2q_pkg::DATA_W-1:0]        quot
);

	localparam int DW   = rm2q_pkg::DIVD_W;
	localparam int RW   = rm2q_pkg::SQ_OUT_W;
	localparam int NS   = rm2q_pkg::DIV_LAT;
	localparam logic [DW-1:0] POS_MAX = DW'((1 << (rm2q_pkg::DATA_W - 1)) - 1);
	localparam logic [DW-1:0] NEG_MAX = DW'(1 << (rm2q_pkg::DATA_W - 1));

	logic [rm2q_pkg::NUM_W-1:0] mag;

	logic [RW-1:0] rem_q [NS];
	logic [DW-1:0] dvd_q [NS];
	logic [DW-1:0] quo_q [NS];
	logic [RW-1:0] den_q [NS];
	logic          neg_q [NS];
	logic          nz_q  [NS];

	logic [RW-1:0] rem_i [NS];
	logic [DW-1:0] dvd_i [NS];
	logic [DW-1:0] quo_i [NS];
	logic [RW-1:0] den_i [NS];
	logic          neg_i [NS];
	logic          nz_i  [NS];
	logic [RW:0]   cur   [NS];
	logic [RW-1:0] rem_n [NS];
	logic          bit_n [NS];

	logic [DW-1:0] qmag;

	assign mag = num[rm2q_pkg::NUM_W-1] ? rm2q_pkg::NUM_W'(-num) : rm2q_pkg::NUM_W'(num);

	always_comb begin
		for (int s = 0; s < NS; s++) begin
			if (s == 0) begin
				rem_i[s] = '0;
				dvd_i[s] = {mag, {rm2q_pkg::FRAC_W{1'b0}}};
				quo_i[s] = '0;
				den_i[s] = den;
				neg_i[s] = num[rm2q_pkg::NUM_W-1];
				nz_i[s]  = (num != '0);
			end else begin
				rem_i[s] = rem_q[s-1];
				dvd_i[s] = dvd_q[s-1];
				quo_i[s] = quo_q[s-1];
				den_i[s] = den_q[s-1];
				neg_i[s] = neg_q[s-1];
				nz_i[s]  = nz_q[s-1];
			end
			cur[s] = {rem_i[s], dvd_i[s][DW-1]};
			// zero divisor: every bit sets, which then saturates unless the numerator is zero
			if (cur[s] >= {1'b0, den_i[s]}) begin
				rem_n[s] = RW'(cur[s] - {1'b0, den_i[s]});
				bit_n[s] = 1'b1;
			end else begin
				rem_n[s] = cur[s][RW-1:0];
				bit_n[s] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int s = 0; s < NS; s++) begin
				rem_q[s] <= rem_n[s];
				dvd_q[s] <= dvd_i[s] << 1;
				quo_q[s] <= {quo_i[s][DW-2:0], bit_n[s]};
				den_q[s] <= den_i[s];
				neg_q[s] <= neg_i[s];
				nz_q[s]  <= nz_i[s];
			end
		end
	end

	assign qmag = quo_q[NS-1];

	always_comb begin
		if (!nz_q[NS-1]) begin
			quot = '0;
		end else if (neg_q[NS-1]) begin
			quot = (qmag > NEG_MAX) ? NEG_MAX[rm2q_pkg::DATA_W-1:0]
				: rm2q_pkg::DATA_W'(rm2q_pkg::DATA_W'(0) - qmag[rm2q_pkg::DATA_W-1:0]);
		end else begin
			quot = (qmag > POS_MAX) ? POS_MAX[rm2q_pkg::DATA_W-1:0]
				: qmag[rm2q_pkg::DATA_W-1:0];
		end
	end

endmodule

`default_nettype wire

[hw/rtl/rm2q_back.sv]
// back end: root, three divides, squared length, root and four divides, output register
`default_nettype none

module rm2q_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire rm2q_pkg::job_t  job,
	input  wire logic            job_vld,
	output logic                 job_take,
	output rm2q_pkg::quat_t      res,
	output logic                 res_vld,
	input  wire logic            res_rdy
);

	localparam int NORM_LAT = rm2q_pkg::SQRT_LAT + rm2q_pkg::DIV_LAT;
	localparam int BACK_LAT = 2 * NORM_LAT + 3;

	typedef struct packed {
		rm2q_pkg::sel_t                sel;
		logic [rm2q_pkg::QUART_W-1:0]  quarter;
	} side2_t;

	typedef struct packed {
		rm2q_pkg::quat_t q;
		logic            unit;
	} side3_t;

	logic en;
	logic [BACK_LAT-1:0] vld_q;
	logic res_vld_q;
	rm2q_pkg::quat_t res_q;

	rm2q_pkg::job_t side1_q [rm2q_pkg::SQRT_LAT];
	side2_t         side2_q [rm2q_pkg::DIV_LAT];
	side3_t         side3_q [NORM_LAT];

	logic [rm2q_pkg::SQ_OUT_W-1:0] scale, nroot;
	logic signed [rm2q_pkg::NUM_W-1:0]  num1 [3];
	logic signed [rm2q_pkg::DATA_W-1:0] quo1 [3];
	logic signed [rm2q_pkg::DATA_W-1:0] qa   [4];
	logic signed [rm2q_pkg::DATA_W-1:0] q_s1 [4];
	logic signed [rm2q_pkg::DATA_W-1:0] q_s2 [4];
	logic [rm2q_pkg::SQR_W-1:0]         sq_s2 [4];
	logic signed [31:0]                 sq_full [4];
	logic [rm2q_pkg::SQ_IN_W-1:0]       nsum, n_s3;
	rm2q_pkg::quat_t                    q_s3;
	logic                               unit_s3;
	logic signed [rm2q_pkg::DATA_W-1:0] num2q [4];
	logic signed [rm2q_pkg::DATA_W-1:0] quo2 [4];
	side2_t sel_side;
	rm2q_pkg::job_t jd;
	rm2q_pkg::quat_t q_out, q_norm;
	logic signed [rm2q_pkg::DATA_W-1:0] quarter16;

	// whole pipe moves together, held while the result waits
	assign en       = !res_vld_q || res_rdy;
	assign job_take = en && job_vld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			res_vld_q <= 1'b0;
		end else if (en) begin
			vld_q     <= {vld_q[BACK_LAT-2:0], job_vld};
			res_vld_q <= vld_q[BACK_LAT-1];
		end
	end

	// first root: scale = isqrt(rad * 2^16)
	rm2q_sqrt u_sqrt_scale (
		.clk  (clk),
		.en   (en),
		.rad  ({job.rad, {(rm2q_pkg::SQ_IN_W - rm2q_pkg::RAD_W){1'b0}}}),
		.root (scale)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			side1_q[0] <= job;
			for (int i = 1; i < rm2q_pkg::SQRT_LAT; i++) side1_q[i] <= side1_q[i-1];
		end
	end

	assign jd      = side1_q[rm2q_pkg::SQRT_LAT-1];
	assign num1[0] = jd.num0;
	assign num1[1] = jd.num1;
	assign num1[2] = jd.num2;

	for (genvar k = 0; k < 3; k++) begin : g_div1
		rm2q_div u_div (
			.clk  (clk),
			.en   (en),
			.num  (num1[k]),
			.den  (scale),
			.quot (quo1[k])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side2_q[0].sel     <= jd.sel;
			side2_q[0].quarter <= scale[rm2q_pkg::SQ_OUT_W-1:2];
			for (int i = 1; i < rm2q_pkg::DIV_LAT; i++) side2_q[i] <= side2_q[i-1];
		end
	end

	assign sel_side  = side2_q[rm2q_pkg::DIV_LAT-1];
	assign quarter16 = rm2q_pkg::DATA_W'(sel_side.quarter);

	// quarter goes in at the chosen component, quotients fill the rest in order
	always_comb begin
		unique case (sel_side.sel)
			rm2q_pkg::SEL_X: begin
				qa[0] = quarter16; qa[1] = quo1[0]; qa[2] = quo1[1]; qa[3] = quo1[2];
			end
			rm2q_pkg::SEL_Y: begin
				qa[0] = quo1[0]; qa[1] = quarter16; qa[2] = quo1[1]; qa[3] = quo1[2];
			end
			rm2q_pkg::SEL_Z: begin
				qa[0] = quo1[0]; qa[1] = quo1[1]; qa[2] = quarter16; qa[3] = quo1[2];
			end
			rm2q_pkg::SEL_W: begin
				qa[0] = quo1[0]; qa[1] = quo1[1]; qa[2] = quo1[2]; qa[3] = quarter16;
			end
			default: begin
				qa[0] = '0; qa[1] = '0; qa[2] = '0; qa[3] = '0;
			end
		endcase
	end

	always_comb begin
		for (int k = 0; k < 4; k++) sq_full[k] = q_s1[k] * q_s1[k];
		nsum = rm2q_pkg::SQ_IN_W'(sq_s2[0]) + rm2q_pkg::SQ_IN_W'(sq_s2[1])
			+ rm2q_pkg::SQ_IN_W'(sq_s2[2]) + rm2q_pkg::SQ_IN_W'(sq_s2[3]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++) begin
				q_s1[k]  <= qa[k];
				q_s2[k]  <= q_s1[k];
				sq_s2[k] <= sq_full[k][rm2q_pkg::SQR_W-1:0];
			end
			n_s3    <= nsum;
			unit_s3 <= (nsum == rm2q_pkg::UNIT_NORM);
			q_s3    <= '{x: q_s2[0], y: q_s2[1], z: q_s2[2], w: q_s2[3]};
		end
	end

	// second root: length of the quaternion
	rm2q_sqrt u_sqrt_norm (
		.clk  (clk),
		.en   (en),
		.rad  (n_s3),
		.root (nroot)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			side3_q[0].q    <= q_s3;
			side3_q[0].unit <= unit_s3;
			for (int i = 1; i < NORM_LAT; i++) side3_q[i] <= side3_q[i-1];
		end
	end

	assign num2q[0] = side3_q[rm2q_pkg::SQRT_LAT-1].q.x;
	assign num2q[1] = side3_q[rm2q_pkg::SQRT_LAT-1].q.y;
	assign num2q[2] = side3_q[rm2q_pkg::SQRT_LAT-1].q.z;
	assign num2q[3] = side3_q[rm2q_pkg::SQRT_LAT-1].q.w;

	for (genvar k = 0; k < 4; k++) begin : g_div2
		rm2q_div u_div (
			.clk  (clk),
			.en   (en),
			.num  (rm2q_pkg::NUM_W'(num2q[k])),
			.den  (nroot),
			.quot (quo2[k])
		);
	end

	assign q_norm = '{x: quo2[0], y: quo2[1], z: quo2[2], w: quo2[3]};
	assign q_out  = side3_q[NORM_LAT-1].unit ? side3_q[NORM_LAT-1].q : q_norm;

	always_ff @(posedge clk) begin
		if (en && vld_q[BACK_LAT-1]) begin
			res_q <= q_out;
		end
	end

	assign res     = res_q;
	assign res_vld = res_vld_q;

endmodule

`default_nettype wire

[hw/rtl/rotation_matrix_to_quaternion.sv]
// top level: rotation matrix to quaternion converter
//
//  channel  dir  payload                         transfer
//  mat      in   m00..m22, signed Q2.14          valid && ready
//  quat     out  quat_x/y/z/w, signed Q2.14      valid && ready
//
// one matrix per cycle sustained while the output is not stalled; path: front, queue, back, output register
// the back pipe is two 17 stage square roots and two 31 stage dividers plus 3 stages
// between them for the squared length
// reset clears valids, queue pointers and queue count only, no clearing pass
// a stalled output holds the whole back pipe; the four entry queue keeps the front taking
`default_nettype none

module rotation_matrix_to_quaternion (
	input  wire logic    clk,
	input  wire logic    arst_n,
	rm2q_mat_if.sink     mat,
	rm2q_quat_if.source  quat
);

	rm2q_pkg::job_t fr_job, q_job;
	rm2q_pkg::quat_t res;
	logic fr_vld, q_full, q_empty, pop;

	rm2q_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.mat     (mat),
		.job     (fr_job),
		.job_vld (fr_vld),
		.q_full  (q_full)
	);

	rm2q_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_job (fr_job),
		.push   (fr_vld),
		.pop    (pop),
		.rd_job (q_job),
		.full   (q_full),
		.empty  (q_empty)
	);

	rm2q_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job      (q_job),
		.job_vld  (!q_empty),
		.job_take (pop),
		.res      (res),
		.res_vld  (quat.valid),
		.res_rdy  (quat.ready)
	);

	assign quat.quat_x = res.x;
	assign quat.quat_y = res.y;
	assign quat.quat_z = res.z;
	assign quat.quat_w = res.w;

	// accepted matrix lands in the front register
	a_front_load: assert property (@(posedge clk) disable iff (!arst_n)
		mat.valid && mat.ready |=> fr_vld)
		else $error("front register missed a transfer");

	// a full queue stays full until the back takes a job
	a_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		q_full && !pop |=> q_full)
		else $error("queue lost an entry");

	// nothing appears in an empty queue without a pending front job
	a_empty_hold: assert property (@(posedge clk) disable iff (!arst_n)
		q_empty && !fr_vld |=> q_empty)
		else $error("queue filled from nothing");

endmodule

`default_nettype wire

[tb/tb_rotation_matrix_to_quaternion.sv]
// testbench for the rotation matrix to quaternion converter
`timescale 1ns / 100ps
`default_nettype none

module tb_rotation_matrix_to_quaternion;

	localparam int LATENCY = 110;

	typedef struct {
		logic signed [rm2q_pkg::DATA_W-1:0] m [9];
	} matrix_t;

	logic clk;
	logic arst_n;
	int errors;
	int hold_off;
	int items_sent;
	int results_seen;
	rm2q_pkg::quat_t quat_q [$];

	rm2q_mat_if mat ();
	rm2q_quat_if quat ();

	rotation_matrix_to_quaternion u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.mat(mat),
		.quat(quat)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("tb_rotation_matrix_to_quaternion: FAIL");
		$finish;
	end

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint clamp(longint v);
		longint hi;
		hi = (64'sd1 <<< (rm2q_pkg::DATA_W - 1)) - 1;
		if (v > hi)
			return hi;
		if (v < -hi - 1)
			return -hi - 1;
		return v;
	endfunction

	// fixed point quotient, zero divisor saturates unless the numerator is zero
	function automatic longint fix_div(longint num, longint unsigned den);
		longint unsigned mag;
		longint hi;
		hi = (64'sd1 <<< (rm2q_pkg::DATA_W - 1)) - 1;
		if (den == 0) begin
			if (num > 0)
				return hi;
			if (num < 0)
				return -hi - 1;
			return 0;
		end
		mag = (num < 0) ? -num : num;
		mag = (mag << rm2q_pkg::FRAC_W) / den;
		return (num < 0) ? -longint'(mag) : longint'(mag);
	endfunction

	function automatic rm2q_pkg::quat_t matrix_to_quat(matrix_t a);
		longint e [9];
		longint t;
		longint rad;
		longint one;
		rm2q_pkg::sel_t sel;
		longint unsigned ur, scale, quarter, n, r, sq, s;
		longint c [4];
		rm2q_pkg::quat_t res;
		one = 64'sd1 <<< rm2q_pkg::FRAC_W;
		for (int i = 0; i < 9; i++)
			e[i] = a.m[i];
		t = e[0] + e[4] + e[8] + one;
		if (t > 0) begin
			sel = rm2q_pkg::SEL_W;
			rad = t;
		end else if (e[0] > e[4] && e[0] > e[8]) begin
			sel = rm2q_pkg::SEL_X;
			rad = one + e[0] - e[4] - e[8];
		end else if (e[4] > e[8]) begin
			sel = rm2q_pkg::SEL_Y;
			rad = one + e[4] - e[0] - e[8];
		end else begin
			sel = rm2q_pkg::SEL_Z;
			rad = one + e[8] - e[0] - e[4];
		end
		ur = (rad > 0) ? rad : 0;
		scale = int_sqrt(ur << (rm2q_pkg::FRAC_W + 2));
		quarter = int_sqrt(ur << (rm2q_pkg::FRAC_W - 2));
		case (sel)
			rm2q_pkg::SEL_W: begin
				c[0] = fix_div(e[5] - e[7], scale);
				c[1] = fix_div(e[6] - e[2], scale);
				c[2] = fix_div(e[1] - e[3], scale);
				c[3] = quarter;
			end
			rm2q_pkg::SEL_X: begin
				c[0] = quarter;
				c[1] = fix_div(e[3] + e[1], scale);
				c[2] = fix_div(e[2] + e[6], scale);
				c[3] = fix_div(e[5] - e[7], scale);
			end
			rm2q_pkg::SEL_Y: begin
				c[0] = fix_div(e[3] + e[1], scale);
				c[1] = quarter;
				c[2] = fix_div(e[7] + e[5], scale);
				c[3] = fix_div(e[6] - e[2], scale);
			end
			default: begin
				c[0] = fix_div(e[6] + e[2], scale);
				c[1] = fix_div(e[7] + e[5], scale);
				c[2] = quarter;
				c[3] = fix_div(e[1] - e[3], scale);
			end
		endcase
		n = 0;
		for (int i = 0; i < 4; i++) begin
			c[i] = clamp(c[i]);
			sq = (c[i] < 0) ? -c[i] : c[i];
			s = n + sq * sq;
			n = (s < n) ? 64'hffff_ffff_ffff_ffff : s;
		end
		if (n != (64'd1 << (2 * rm2q_pkg::FRAC_W))) begin
			r = int_sqrt(n);
			for (int i = 0; i < 4; i++)
				c[i] = clamp(fix_div(c[i], r));
		end
		res.x = rm2q_pkg::DATA_W'(c[0]);
		res.y = rm2q_pkg::DATA_W'(c[1]);
		res.z = rm2q_pkg::DATA_W'(c[2]);
		res.w = rm2q_pkg::DATA_W'(c[3]);
		return res;
	endfunction

	function automatic int short_gap();
		if ($urandom_range(0, 3) != 0)
			return 0;
		if ($urandom_range(0, 15) == 0)
			return $urandom_range(10, 60);
		return $urandom_range(1, 4);
	endfunction

	// valid stays high between back to back items and drops only for a gap
	task automatic send_matrix(matrix_t a, bit gaps);
		int g;
		g = gaps ? short_gap() : 0;
		if (g > 0) begin
			mat.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		mat.valid <= 1'b1;
		mat.m00 <= a.m[0];
		mat.m01 <= a.m[1];
		mat.m02 <= a.m[2];
		mat.m10 <= a.m[3];
		mat.m11 <= a.m[4];
		mat.m12 <= a.m[5];
		mat.m20 <= a.m[6];
		mat.m21 <= a.m[7];
		mat.m22 <= a.m[8];
		@(posedge clk);
		while (!mat.ready)
			@(posedge clk);
		quat_q.push_back(matrix_to_quat(a));
		items_sent++;
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		mat.valid <= 1'b0;
		while (quat_q.size() != 0 && guard < 200_000) begin
			@(posedge clk);
			guard++;
		end
		repeat (LATENCY) @(posedge clk);
	endtask

	function automatic matrix_t rand_matrix();
		matrix_t a;
		for (int i = 0; i < 9; i++)
			a.m[i] = rm2q_pkg::DATA_W'($urandom());
		return a;
	endfunction

	// near a real rotation: small perturbation of a signed permutation
	function automatic matrix_t rand_rotation();
		matrix_t a;
		int p;
		int sg;
		p = $urandom_range(0, 5);
		for (int i = 0; i < 9; i++)
			a.m[i] = rm2q_pkg::DATA_W'($urandom_range(0, 8000) - 4000);
		for (int r = 0; r < 3; r++) begin
			sg = $urandom_range(0, 1) ? 16384 : -16384;
			case (p)
				0: a.m[r * 3 + r] =
					rm2q_pkg::DATA_W'(sg - $urandom_range(0, 3000) * (sg > 0 ? 1 : -1));
				1: a.m[r * 3 + (r + 1) % 3] = rm2q_pkg::DATA_W'(sg);
				2: a.m[r * 3 + (r + 2) % 3] = rm2q_pkg::DATA_W'(sg);
				default: a.m[r * 3 + ((p + r) % 3)] =
					rm2q_pkg::DATA_W'(sg + $urandom_range(0, 200) - 100);
			endcase
		end
		return a;
	endfunction

	task automatic test_directed();
		matrix_t a;
		// all zero, all extremes, identity, half turns about each axis
		for (int i = 0; i < 9; i++) a.m[i] = '0;
		send_matrix(a, 1'b0);
		for (int i = 0; i < 9; i++) a.m[i] = 16'sh7fff;
		send_matrix(a, 1'b0);
		for (int i = 0; i < 9; i++) a.m[i] = 16'sh8000;
		send_matrix(a, 1'b0);
		for (int i = 0; i < 9; i++) a.m[i] = (i % 2) ? 16'sh8000 : 16'sh7fff;
		send_matrix(a, 1'b0);
		for (int i = 0; i < 9; i++) a.m[i] = (i % 2) ? 16'sh7fff : 16'sh8000;
		send_matrix(a, 1'b0);
		for (int i = 0; i < 9; i++) a.m[i] = (i % 4 == 0) ? 16'sd16384 : 16'sd0;
		send_matrix(a, 1'b0);
		for (int k = 0; k < 3; k++) begin
			for (int i = 0; i < 9; i++)
				a.m[i] = (i % 4 == 0) ? ((i / 4 == k) ? 16'sd16384 : -16'sd16384) : 16'sd0;
			send_matrix(a, 1'b0);
		end
		// ties on the diagonal with trace +1 not positive
		for (int i = 0; i < 9; i++) a.m[i] = 16'sd100;
		a.m[0] = -16'sd8192; a.m[4] = -16'sd8192; a.m[8] = -16'sd8192;
		send_matrix(a, 1'b0);
		a.m[0] = -16'sd4000; a.m[4] = -16'sd4000; a.m[8] = -16'sd9000;
		send_matrix(a, 1'b0);
		a.m[0] = -16'sd9000; a.m[4] = -16'sd4000; a.m[8] = -16'sd4000;
		send_matrix(a, 1'b0);
		// trace branch off: the tie of m00 and m11 falls to the z branch, whose radicand is positive
		for (int i = 0; i < 9; i++) a.m[i] = 16'sd300;
		a.m[0] = -16'sd20000; a.m[4] = -16'sd20000; a.m[8] = 16'sd12000;
		send_matrix(a, 1'b0);
		// trace exactly -1
		a.m[0] = -16'sd16384; a.m[4] = 16'sd0; a.m[8] = 16'sd0;
		send_matrix(a, 1'b0);
		// large off-diagonal with tiny scale
		for (int i = 0; i < 9; i++) a.m[i] = (i % 2) ? 16'sh7fff : 16'sh8000;
		a.m[0] = -16'sd16383; a.m[4] = 16'sd0; a.m[8] = 16'sd0;
		send_matrix(a, 1'b0);
		drain();
	endtask

	task automatic test_random();
		for (int k = 0; k < 1500; k++)
			send_matrix(($urandom_range(0, 3) == 0) ? rand_matrix() : rand_rotation(), 1'b1);
		drain();
	endtask

	// sink stalls a long while, source keeps offering until the block backs up
	task automatic test_backpressure();
		hold_off = 300;
		for (int k = 0; k < 200; k++)
			send_matrix(rand_rotation(), 1'b0);
		drain();
	endtask

	// each result lands in an empty pipe
	task automatic test_single_flight();
		for (int k = 0; k < 10; k++) begin
			send_matrix(rand_matrix(), 1'b0);
			drain();
		end
	endtask

	// sink ready with random stalls
	initial begin
		int g;
		quat.ready = 1'b0;
		hold_off = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off > 0) begin
				quat.ready <= 1'b0;
				hold_off--;
			end else begin
				g = short_gap();
				quat.ready <= (g == 0);
				if (g > 1)
					hold_off = g - 1;
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		rm2q_pkg::quat_t want;
		if (arst_n && quat.valid && quat.ready) begin
			results_seen++;
			if (quat_q.size() == 0) begin
				$display("%0t: unexpected result x=%0d y=%0d z=%0d w=%0d", $time,
					quat.quat_x, quat.quat_y, quat.quat_z, quat.quat_w);
				errors++;
			end else begin
				want = quat_q.pop_front();
				if (quat.quat_x !== want.x) begin
					$display("%0t: quat_x expected %0d actual %0d", $time, want.x, quat.quat_x);
					errors++;
				end
				if (quat.quat_y !== want.y) begin
					$display("%0t: quat_y expected %0d actual %0d", $time, want.y, quat.quat_y);
					errors++;
				end
				if (quat.quat_z !== want.z) begin
					$display("%0t: quat_z expected %0d actual %0d", $time, want.z, quat.quat_z);
					errors++;
				end
				if (quat.quat_w !== want.w) begin
					$display("%0t: quat_w expected %0d actual %0d", $time, want.w, quat.quat_w);
					errors++;
				end
			end
		end
	end

	initial begin
		errors = 0;
		items_sent = 0;
		results_seen = 0;
		arst_n = 1'b0;
		mat.valid = 1'b0;
		mat.m00 = '0; mat.m01 = '0; mat.m02 = '0;
		mat.m10 = '0; mat.m11 = '0; mat.m12 = '0;
		mat.m20 = '0; mat.m21 = '0; mat.m22 = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_backpressure();
		test_single_flight();
		test_random();
		if (quat_q.size() != 0) begin
			$display("%0t: %0d results missing", $time, quat_q.size());
			errors++;
		end
		if (errors == 0)
			$display("tb_rotation_matrix_to_quaternion: PASS");
		else
			$display("tb_rotation_matrix_to_quaternion: FAIL");
		$finish;
	end

endmodule

`default_nettype wire
